// File: sv/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types, constants and helpers of the text console core.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = 11;   // cell_index / cursor_pos field width
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int OP_W   = 2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;
  localparam logic [CELL_W-1:0] RESET_BLANK  = {RESET_COLOR, CH_SPACE};

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    mem_wr_t           wr;
    logic              scroll;
    logic [ADDR_W-1:0] pos;
    logic [ADDR_W-1:0] pos_next;
  } cur_info_t;

  typedef struct packed {
    logic              go;
    logic              scroll;
    logic [CELL_W-1:0] blank;
  } sweep_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ADDR_W-1:0] rd_addr;
  } sweep_stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(int'(row) * COLUMNS + int'(col));
  endfunction

endpackage

// File: sv/tccs_ram.sv
// ----------------------------------------------------------------------------
// tccs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/tccs_cursor.sv
// ----------------------------------------------------------------------------
// tccs_cursor
// Cursor registers and the put-character decode: cell write and next cursor.
// ----------------------------------------------------------------------------
module tccs_cursor
  import tccs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              put,
  input  logic              home,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [CHAR_W-1:0] color,
  output cur_info_t         info
);

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W:0]   col_next;
  logic [ROW_W:0]   row_next;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic             scroll;

  always_comb begin
    col_next = {1'b0, col};
    row_next = {1'b0, row};
    wr_en    = 1'b0;
    wr_addr  = cell_addr(row, col);
    wr_data  = {color, char_code};
    if (char_code == CH_NEWLINE) begin
      col_next = '0;
      row_next = row_next + 1'b1;
    end else if (char_code == CH_BACKSPACE) begin
      if (col != '0) begin
        col_next = col_next - 1'b1;
        wr_en    = 1'b1;
        wr_addr  = cell_addr(row, col - 1'b1);
        wr_data  = {color, CH_SPACE};
      end
    end else if (char_code == CH_RETURN) begin
      col_next = '0;
    end else begin
      wr_en    = 1'b1;
      col_next = col_next + 1'b1;
    end
    // wrap at end of row
    if (col_next >= (COL_W+1)'(COLUMNS)) begin
      col_next = '0;
      row_next = row_next + 1'b1;
    end
    scroll = (row_next >= (ROW_W+1)'(ROWS));
    if (scroll) begin
      row_next = (ROW_W+1)'(ROWS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || home) begin
      col <= '0;
      row <= '0;
    end else if (put) begin
      col <= col_next[COL_W-1:0];
      row <= row_next[ROW_W-1:0];
    end
  end

  assign info.wr.en   = put & wr_en;
  assign info.wr.addr = wr_addr;
  assign info.wr.data = wr_data;
  assign info.scroll  = scroll;
  assign info.pos     = cell_addr(row, col);
  assign info.pos_next = cell_addr(row_next[ROW_W-1:0], col_next[COL_W-1:0]);

endmodule

// File: sv/tccs_sweep.sv
// ----------------------------------------------------------------------------
// tccs_sweep
// Whole-screen walker: blank fill or scroll-up copy, one cell per cycle.
// ----------------------------------------------------------------------------
module tccs_sweep
  import tccs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  sweep_cmd_t        cmd,
  input  logic [CELL_W-1:0] rd_data,
  output mem_wr_t           wr,
  output sweep_stat_t       stat
);

  localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELL_COUNT - COLUMNS);

  logic              busy;
  logic              scroll;
  logic [CELL_W-1:0] blank;
  logic [ADDR_W-1:0] idx;
  // write stage, the cycle after the read issue
  logic              stg_valid;
  logic              stg_last;
  logic              stg_from_mem;
  logic [ADDR_W-1:0] stg_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;       // reset clear pass
      scroll    <= 1'b0;
      blank     <= RESET_BLANK;
      idx       <= '0;
      stg_valid <= 1'b0;
    end else begin
      if (cmd.go) begin
        busy   <= 1'b1;
        scroll <= cmd.scroll;
        blank  <= cmd.blank;
        idx    <= '0;
      end else if (busy) begin
        idx <= idx + 1'b1;
        if (idx == LAST_IDX) begin
          busy <= 1'b0;
        end
      end
      stg_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    stg_addr     <= idx;
    stg_last     <= (idx == LAST_IDX);
    stg_from_mem <= scroll && (idx < COPY_END);
  end

  assign stat.busy    = busy;
  assign stat.done    = stg_valid & stg_last;
  assign stat.rd_addr = idx + ADDR_W'(COLUMNS);

  assign wr.en   = stg_valid;
  assign wr.addr = stg_addr;
  assign wr.data = stg_from_mem ? rd_data : blank;

endmodule

// File: sv/text_console_cursor_scroll_core.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core
// Text console engine: 80x25 cell screen memory with cursor, scroll and clear.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_axis): tuser carries the op (0 put char, 1 clear screen,
//   2 read cell, 3 no-op); tdata carries char_code and cell_index.
//   Output stream (m_axis): one transaction per input transaction, carrying
//   the linear cursor position after the op and the read cell (0 unless op 2).
//   Config channel (cfg_*): writes text_color; always ready, to be written
//   only while the core is idle.
// Timing
//   The screen lives in one RAM with a registered read port.
//   Put char (no scroll) and no-op: the result is loaded at accept.
//   Read cell: the result is loaded in ST_READ from the registered read port.
//   Clear and scroll: the result waits for the sweep that walks the RAM one
//   cell per cycle; scroll reads row r+1 and writes row r.
// Reset
//   After rst the core blanks the RAM (0x0720 per cell) before s_axis_tready
//   rises; config writes are taken meanwhile.
// Stall
//   The result sits in an output register; a new transaction is accepted while
//   the core is idle and that register is empty or being taken in the same cycle.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core
  import tccs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] char_code, [18:8] cell_index
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [10:0] cursor_pos, [26:11] cell_data
  // config write (text_color)
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  state_t state, state_next;

  logic [CHAR_W-1:0] text_color;

  // input field split
  op_t               in_op;
  logic [CHAR_W-1:0] in_char;
  logic [ADDR_W-1:0] in_index;
  assign in_op    = op_t'(s_axis_tuser);
  assign in_char  = s_axis_tdata[CHAR_W-1:0];
  assign in_index = s_axis_tdata[CHAR_W +: ADDR_W];

  logic in_accept;
  assign in_accept = s_axis_tvalid & s_axis_tready;

  // submodule links
  cur_info_t         cur;
  sweep_cmd_t        sw_cmd;
  sweep_stat_t       sw_stat;
  mem_wr_t           sw_wr;
  logic [CELL_W-1:0] rd_data;
  logic              cur_put;
  logic              cur_home;

  // output register
  logic              out_valid;
  logic [ADDR_W-1:0] out_pos;
  logic [CELL_W-1:0] out_cell;
  logic              out_load;
  logic [ADDR_W-1:0] load_pos;
  logic [CELL_W-1:0] load_cell;
  logic              rd_in_range;

  // --------------------------------------------------------------------------
  // Config register
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      text_color <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Control FSM
  // --------------------------------------------------------------------------
  assign s_axis_tready = (state == ST_IDLE) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sw_stat.done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_PUT:   state_next = cur.scroll ? ST_SWEEP : ST_IDLE;
            OP_CLEAR: state_next = ST_SWEEP;
            OP_READ:  state_next = ST_READ;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_next = ST_IDLE;
      ST_SWEEP: begin
        if (sw_stat.done) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cur_put       = 1'b0;
    cur_home      = 1'b0;
    sw_cmd.go     = 1'b0;
    sw_cmd.scroll = 1'b0;
    sw_cmd.blank  = {text_color, CH_SPACE};
    out_load      = 1'b0;
    load_pos      = cur.pos;
    load_cell     = '0;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_PUT: begin
              cur_put       = 1'b1;
              sw_cmd.go     = cur.scroll;
              sw_cmd.scroll = 1'b1;
              out_load      = !cur.scroll;
              load_pos      = cur.pos_next;
            end
            OP_CLEAR: begin
              cur_home  = 1'b1;
              sw_cmd.go = 1'b1;
            end
            OP_READ: ;
            default: out_load = 1'b1;   // no-op: cursor only
          endcase
        end
      end
      ST_READ: begin
        out_load  = 1'b1;
        load_cell = rd_in_range ? rd_data : '0;
      end
      ST_SWEEP: out_load = sw_stat.done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_in_range <= (in_index < ADDR_W'(CELL_COUNT));
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos  <= load_pos;
      out_cell <= load_cell;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_cell, out_pos};

  // --------------------------------------------------------------------------
  // Cursor, sweep and screen RAM
  // --------------------------------------------------------------------------
  tccs_cursor u_cursor (
    .clk       (clk),
    .rst       (rst),
    .put       (cur_put),
    .home      (cur_home),
    .char_code (in_char),
    .color     (text_color),
    .info      (cur)
  );

  tccs_sweep u_sweep (
    .clk     (clk),
    .rst     (rst),
    .cmd     (sw_cmd),
    .rd_data (rd_data),
    .wr      (sw_wr),
    .stat    (sw_stat)
  );

  // sweep and put writes never overlap: puts are taken only when idle
  mem_wr_t           ram_wr;
  logic [ADDR_W-1:0] ram_raddr;
  assign ram_wr    = sw_wr.en ? sw_wr : cur.wr;
  assign ram_raddr = sw_stat.busy ? sw_stat.rd_addr : in_index;

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    !(sw_wr.en && cur.wr.en))
    else $error("sweep and cursor write the screen in the same cycle");

  a_no_result_in_init: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT) |-> !m_axis_tvalid)
    else $error("result produced during reset clear");

  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !out_valid)
    else $error("read result would overwrite a pending result");

  a_cursor_in_screen: assert property (@(posedge clk) disable iff (rst)
    cur.pos < ADDR_W'(CELL_COUNT))
    else $error("cursor left the screen");

  a_sweep_ends_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && sw_stat.done) |=> (state == ST_IDLE && m_axis_tvalid))
    else $error("sweep completion did not post a result");

endmodule

// File: tb/text_console_cursor_scroll_core_tb.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core_tb
// Self-checking bench for the text console core: commands stream in, results
// are checked against an in-bench screen/cursor model, text_color is swept
// between phases, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tccs_pkg::*;

  // Hard stop; the run is dominated by the sweeps of scroll and clear, and the
  // limit still covers every command sweeping under stalls.
  localparam int CYCLE_LIMIT = 20_000_000;

  typedef struct {
    op_t               op;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_index;
  } console_cmd_t;

  typedef struct {
    logic [ADDR_W-1:0] cursor_pos;
    logic [CELL_W-1:0] cell_data;
  } cursor_cell_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [7:0] char_code, [18:8] cell_index
  logic [1:0]  s_axis_tuser = '0;   // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [10:0] cursor_pos, [26:11] cell_data
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  // Console model state
  logic [CELL_W-1:0] screen_mem [CELL_COUNT];
  int unsigned       cur_col;
  int unsigned       cur_row;
  logic [CHAR_W-1:0] text_color;

  console_cmd_t cmd_q[$];        // commands waiting to be driven
  console_cmd_t in_flight;       // command currently on s_axis
  cursor_cell_t cursor_cell_q[$];// predicted results, oldest first
  cursor_cell_t got_result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int accepted_count = 0;
  int result_count  = 0;
  int scroll_count  = 0;
  int clear_count   = 0;
  int read_count    = 0;
  longint unsigned cycle_count = 0;

  text_console_cursor_scroll_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Blank cell uses the color in force at the time of the write.
  function automatic logic [CELL_W-1:0] blank_cell();
    return {text_color, CH_SPACE};
  endfunction

  // Applies one accepted command to the model and queues its result.
  function automatic void console_apply(input console_cmd_t cmd);
    cursor_cell_t res;
    res.cell_data = '0;
    case (cmd.op)
      OP_PUT: begin
        if (cmd.char_code == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (cmd.char_code == CH_BACKSPACE) begin
          // backspace at column zero leaves everything as is
          if (cur_col > 0) begin
            cur_col--;
            screen_mem[cur_row * COLUMNS + cur_col] = blank_cell();
          end
        end else if (cmd.char_code == CH_RETURN) begin
          cur_col = 0;
        end else begin
          screen_mem[cur_row * COLUMNS + cur_col] = {text_color, cmd.char_code};
          cur_col++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        // past the last row: shift up one row, blank the bottom row
        if (cur_row >= ROWS) begin
          for (int i = 0; i < COLUMNS * (ROWS - 1); i++)
            screen_mem[i] = screen_mem[i + COLUMNS];
          for (int i = COLUMNS * (ROWS - 1); i < CELL_COUNT; i++)
            screen_mem[i] = blank_cell();
          cur_row = ROWS - 1;
          scroll_count++;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++)
          screen_mem[i] = blank_cell();
        cur_col = 0;
        cur_row = 0;
        clear_count++;
      end
      OP_READ: begin
        // reads past the screen return zero
        if (cmd.cell_index < CELL_COUNT)
          res.cell_data = screen_mem[cmd.cell_index];
        read_count++;
      end
      default: ;  // unused op: no state change
    endcase
    res.cursor_pos = ADDR_W'(cur_row * COLUMNS + cur_col);
    cursor_cell_q.push_back(res);
  endfunction

  function automatic console_cmd_t make_cmd(input op_t op, input int ch, input int idx);
    console_cmd_t cmd;
    cmd.op         = op;
    cmd.char_code  = CHAR_W'(ch);
    cmd.cell_index = ADDR_W'(idx);
    return cmd;
  endfunction

  // Text content: mostly printable, with some raw bytes and edit codes.
  function automatic int pick_text_char();
    int r;
    r = $urandom_range(99);
    if (r < 5) return int'(CH_BACKSPACE);
    if (r < 8) return int'(CH_RETURN);
    if (r < 16) return $urandom_range(255);
    return $urandom_range(8'h20, 8'h7E);
  endfunction

  // Appends random command sequences: text runs, newline runs, cell reads,
  // clears, no-ops and some fully random noise.
  task automatic queue_random_cmds(input int count);
    int added;
    int kind;
    int len;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // short runs mostly, long ones to force row wrap
        len = ($urandom_range(4) == 0) ? $urandom_range(81, 170) : $urandom_range(1, 40);
        repeat (len)
          cmd_q.push_back(make_cmd(OP_PUT, pick_text_char(), $urandom_range(2047)));
      end else if (kind < 55) begin
        // long newline runs walk the cursor down to the scrolling region
        len = ($urandom_range(5) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 6);
        repeat (len)
          cmd_q.push_back(make_cmd(OP_PUT, CH_NEWLINE, $urandom_range(2047)));
      end else if (kind < 77) begin
        len = $urandom_range(1, 6);
        repeat (len)
          cmd_q.push_back(make_cmd(OP_READ, $urandom_range(255), $urandom_range(2047)));
      end else if (kind < 85) begin
        len = 1;
        cmd_q.push_back(make_cmd(OP_CLEAR, $urandom_range(255), $urandom_range(2047)));
      end else if (kind < 90) begin
        len = 1;
        cmd_q.push_back(make_cmd(OP_NOP, $urandom_range(255), $urandom_range(2047)));
      end else begin
        len = 1;
        cmd_q.push_back(make_cmd(op_t'($urandom_range(3)), $urandom_range(255),
                                 $urandom_range(2047)));
      end
      added += len;
    end
  endtask

  // Holds until every queued command is accepted and every result is back.
  // Sampled at the falling edge so the clocked blocks have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (cmd_q.size() != 0 || s_axis_tvalid || cursor_cell_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_color(input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    text_color = value;
    cfg_valid <= 1'b0;
  endtask

  // Command driver: loads the next command when the slot is free, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        console_apply(in_flight);
        accepted_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'd0, in_flight.cell_index, in_flight.char_code};
          s_axis_tuser  <= in_flight.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (cursor_cell_q.size() == 0) begin
          $error("result with nothing pending: cursor_pos %0d, cell_data 0x%04h",
                 m_axis_tdata[10:0], m_axis_tdata[26:11]);
          error_count++;
        end else begin
          got_result = cursor_cell_q.pop_front();
          if (m_axis_tdata[10:0] !== got_result.cursor_pos) begin
            $error("cursor_pos: expected %0d, got %0d",
                   got_result.cursor_pos, m_axis_tdata[10:0]);
            error_count++;
          end
          if (m_axis_tdata[26:11] !== got_result.cell_data) begin
            $error("cell_data: expected 0x%04h, got 0x%04h",
                   got_result.cell_data, m_axis_tdata[26:11]);
            error_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_console_cursor_scroll_core_tb: done, errors");
      $finish;
    end
  end

  initial begin
    // model reset: every cell a space with the reset color, cursor home
    text_color = RESET_COLOR;
    cur_col    = 0;
    cur_row    = 0;
    for (int i = 0; i < CELL_COUNT; i++)
      screen_mem[i] = RESET_BLANK;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // the core blanks its RAM before taking commands
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);

    // Directed: field extremes, every op, edit codes, high bytes
    write_color(8'hFF);
    @(negedge clk);
    cmd_q.push_back(make_cmd(OP_READ,  8'h00, 0));       // reset blank
    cmd_q.push_back(make_cmd(OP_READ,  8'h00, CELL_COUNT - 1));
    cmd_q.push_back(make_cmd(OP_READ,  8'h00, CELL_COUNT)); // off screen
    cmd_q.push_back(make_cmd(OP_READ,  8'hFF, 2047));
    cmd_q.push_back(make_cmd(OP_PUT,   8'h41, 2047));
    cmd_q.push_back(make_cmd(OP_PUT,   8'hFF, 0));
    cmd_q.push_back(make_cmd(OP_PUT,   8'h00, 0));
    cmd_q.push_back(make_cmd(OP_PUT,   8'h80, 0));
    cmd_q.push_back(make_cmd(OP_PUT,   CH_BACKSPACE, 0));
    cmd_q.push_back(make_cmd(OP_READ,  8'h00, 3));       // blanked by backspace
    cmd_q.push_back(make_cmd(OP_READ,  8'h00, 1));
    cmd_q.push_back(make_cmd(OP_PUT,   CH_RETURN, 0));
    cmd_q.push_back(make_cmd(OP_PUT,   CH_BACKSPACE, 0)); // at column zero
    cmd_q.push_back(make_cmd(OP_PUT,   8'h7F, 0));
    cmd_q.push_back(make_cmd(OP_PUT,   CH_NEWLINE, 0));
    cmd_q.push_back(make_cmd(OP_READ,  8'h00, 0));
    cmd_q.push_back(make_cmd(OP_NOP,   8'hFF, 2047));
    cmd_q.push_back(make_cmd(OP_CLEAR, 8'hFF, 2047));
    cmd_q.push_back(make_cmd(OP_READ,  8'h00, 1));
    cmd_q.push_back(make_cmd(OP_READ,  8'h00, COLUMNS));
    wait_drained();

    // Phase 1: sender idles 25%, receiver 56%
    write_color(8'h00);
    @(negedge clk);
    send_idle_pct = 25;
    recv_idle_pct = 56;
    queue_random_cmds(350);
    wait_drained();

    // Phase 2: roles swapped; sender holds off mid-phase until drained
    write_color(8'(($urandom_range(1, 254))));
    @(negedge clk);
    send_idle_pct = 56;
    recv_idle_pct = 25;
    queue_random_cmds(175);
    wait_drained();
    queue_random_cmds(175);
    wait_drained();

    // Phase 3: no idling on either side
    write_color(8'hFF);
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_cmds(350);
    wait_drained();
    repeat (16) @(negedge clk);

    if (cursor_cell_q.size() != 0) begin
      $error("%0d predicted results never arrived", cursor_cell_q.size());
      error_count++;
    end

    $display("ran %0d commands / %0d results in %0d cycles", accepted_count,
             result_count, cycle_count);
    $display("  %0d scrolls, %0d clears, %0d cell reads, 4 text color writes",
             scroll_count, clear_count, read_count);
    if (error_count == 0) begin
      $display("text_console_cursor_scroll_core_tb: done, clean");
    end else begin
      $display("text_console_cursor_scroll_core_tb: done, errors");
    end
    $finish;
  end

endmodule
